### hdl/lca_pkg.sv
package lca_pkg;

  localparam int FIELD_W = 10;
  localparam int CFG_W   = 10;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_BUILD = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_FIX_RD,
    ST_FIX_WR,
    ST_P_RD,
    ST_P_CHK,
    ST_P_WR,
    ST_R_RD,
    ST_R_WR,
    ST_L_RD1,
    ST_L_RD2,
    ST_L_WR,
    ST_Q_DY,
    ST_Q_SET,
    ST_LF_A,
    ST_LF_B,
    ST_LF_C,
    ST_LF_G,
    ST_LF_H,
    ST_LF_I,
    ST_J_A,
    ST_J_B,
    ST_J_C,
    ST_F_A,
    ST_F_B,
    ST_F_C,
    ST_Q_OUT
  } state_t;

endpackage

### hdl/lca_in_if.sv
interface lca_in_if import lca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [FIELD_W-1:0] node_a;
  logic [FIELD_W-1:0] node_b;

  modport source (output valid, output mode, output node_a, output node_b, input ready);
  modport sink (input valid, input mode, input node_a, input node_b, output ready);
endinterface

### hdl/lca_out_if.sv
interface lca_out_if import lca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] common_ancestor;
  logic               query_error;

  modport source (output valid, output common_ancestor, output query_error, input ready);
  modport sink (input valid, input common_ancestor, input query_error, output ready);
endinterface

### hdl/lca_binary_lifting_top.sv
// Lowest common ancestor by binary lifting over a parent table of nodes 1..node_count
// (node 0 means no parent). One beat goes in at a time; in_ch.ready is high only
// while the sequencer is idle. Set parent leaves the sequencer idle. Clear, and the
// pass that follows reset, sweep all 2^NODE_BITS entries (1024 by default) of the
// parent level of the ancestor memory, during which no beat is taken. Build checks
// parents, then runs depth passes, up to n+1 of them (n+1 for a chain entered in
// reverse order, 2 for a well-ordered tree), then the cycle sweep, then one pass per
// doubling level for LEVELS-1 levels. A valid query lifts each node to the other's
// depth, jumps both from the top level down, then takes single parent steps: usually
// one for the final step up to the common ancestor, more when LEVELS cannot span a
// depth gap; an invalid query goes straight to the output stage. The ancestor memory
// and the depth memory each have a single read port with a registered read. A result
// waits in the output register until taken, and a query that finishes while it waits
// holds until the register frees up.
module lca_binary_lifting_top import lca_pkg::*; #(
  parameter int NODE_BITS = 10,
  parameter int LEVELS    = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  lca_in_if.sink           in_ch,
  lca_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int NB  = NODE_BITS;
  localparam int LB  = $clog2(LEVELS);
  localparam int AW  = (NB > FIELD_W) ? NB : FIELD_W;
  localparam int CW  = (AW > CFG_W) ? AW : CFG_W;
  localparam logic [CW-1:0] CAP = CW'((64'd1 << NB) - 64'd1);
  localparam logic [LB-1:0] K_TOP = LB'(LEVELS - 1);

  // Control state.
  state_t          state_r, state_nxt;
  logic [NB-1:0]   i_r, i_nxt;
  logic [LB-1:0]   k_r, k_nxt;
  logic            changed_r, changed_nxt;
  logic            built_r, built_nxt;
  logic            phase_r, phase_nxt;
  logic [CFG_W-1:0] cfg_r, cfg_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Working payload.
  logic [NB-1:0]   x_r, x_nxt;
  logic [NB-1:0]   y_r, y_nxt;
  logic [NB-1:0]   cur_r, cur_nxt;
  logic [NB-1:0]   cand_r, cand_nxt;
  logic [NB-1:0]   t_r, t_nxt;
  logic [NB-1:0]   res_r, res_nxt;
  logic            qerr_r, qerr_nxt;
  logic [NB-1:0]   out_ca_r, out_ca_nxt;
  logic            out_err_r, out_err_nxt;

  // Memory ports.
  logic [NB-1:0]   anc_mem [LEVELS * (1 << NB)];
  logic [NB-1:0]   dep_mem [1 << NB];
  logic [LB-1:0]   anc_rlvl, anc_wlvl;
  logic [NB-1:0]   anc_rnode, anc_wnode, anc_wdata;
  logic            anc_we;
  logic [NB-1:0]   dep_raddr, dep_waddr, dep_wdata;
  logic            dep_we;
  logic [NB-1:0]   anc_rd_r, dep_rd_r;
  logic            anc_zero_r, dep_zero_r;
  logic [NB-1:0]   anc_q, dep_q;

  // Decoded inputs.
  logic            acc;
  logic [AW-1:0]   a_w, b_w;
  logic [NB-1:0]   a_nb, b_nb, n_nb;
  logic [CW-1:0]   cfg_w, n_w, a_c, b_c;
  logic            a_ok, b_ok, b_par_ok;
  logic            i_last;
  logic            chg;

  assign acc     = in_ch.valid && in_ch.ready;
  assign a_w     = AW'(in_ch.node_a);
  assign b_w     = AW'(in_ch.node_b);
  assign a_nb    = a_w[NB-1:0];
  assign b_nb    = b_w[NB-1:0];
  assign a_c     = CW'(in_ch.node_a);
  assign b_c     = CW'(in_ch.node_b);
  assign cfg_w   = CW'(cfg_r);
  assign n_w     = (cfg_w < CAP) ? cfg_w : CAP;
  assign n_nb    = n_w[NB-1:0];
  assign a_ok    = (a_c != '0) && (a_c <= n_w);
  assign b_ok    = (b_c != '0) && (b_c <= n_w);
  assign b_par_ok = (b_c <= n_w);
  assign i_last  = (i_r == n_nb);

  // Node 0 reads as zero at every level.
  assign anc_q = anc_zero_r ? '0 : anc_rd_r;
  assign dep_q = dep_zero_r ? '0 : dep_rd_r;

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.common_ancestor = FIELD_W'(out_ca_r);
  assign out_ch.query_error     = out_err_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:    if (&i_r) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (acc) begin
          case (in_ch.mode)
            MODE_CLEAR: state_nxt = ST_CLR;
            MODE_SET:   state_nxt = ST_IDLE;
            MODE_BUILD: state_nxt = (n_nb == '0) ? ST_IDLE : ST_FIX_RD;
            default:    state_nxt = (!built_r || !a_ok || !b_ok) ? ST_Q_OUT : ST_Q_DY;
          endcase
        end
      end
      ST_FIX_RD: state_nxt = ST_FIX_WR;
      ST_FIX_WR: state_nxt = i_last ? ST_P_RD : ST_FIX_RD;
      ST_P_RD:   state_nxt = ST_P_CHK;
      ST_P_CHK: begin
        if (dep_q == '0 && anc_q != '0) state_nxt = ST_P_WR;
        else if (i_last)                state_nxt = chg ? ST_P_RD : ST_R_RD;
        else                            state_nxt = ST_P_RD;
      end
      ST_P_WR:   state_nxt = (i_last && !chg) ? ST_R_RD : ST_P_RD;
      ST_R_RD:   state_nxt = ST_R_WR;
      ST_R_WR:   state_nxt = i_last ? ST_L_RD1 : ST_R_RD;
      ST_L_RD1:  state_nxt = ST_L_RD2;
      ST_L_RD2:  state_nxt = ST_L_WR;
      ST_L_WR:   state_nxt = (i_last && k_r == K_TOP) ? ST_IDLE : ST_L_RD1;
      ST_Q_DY:   state_nxt = ST_Q_SET;
      ST_Q_SET:  state_nxt = ST_LF_A;
      ST_LF_A:   state_nxt = ST_LF_B;
      ST_LF_B:   state_nxt = ST_LF_C;
      ST_LF_C:   state_nxt = (k_r == '0) ? ST_LF_G : ST_LF_A;
      ST_LF_G:   state_nxt = ST_LF_H;
      ST_LF_H: begin
        if (dep_q > t_r)  state_nxt = ST_LF_I;
        else if (!phase_r) state_nxt = ST_LF_A;
        else              state_nxt = ST_J_A;
      end
      ST_LF_I:   state_nxt = ST_LF_G;
      ST_J_A:    state_nxt = ST_J_B;
      ST_J_B:    state_nxt = ST_J_C;
      ST_J_C:    state_nxt = (k_r == '0) ? ST_F_A : ST_J_A;
      ST_F_A:    state_nxt = (x_r == y_r) ? ST_Q_OUT : ST_F_B;
      ST_F_B:    state_nxt = ST_F_C;
      ST_F_C:    state_nxt = ST_F_A;
      ST_Q_OUT:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    i_nxt       = i_r;
    k_nxt       = k_r;
    changed_nxt = changed_r;
    built_nxt   = built_r;
    phase_nxt   = phase_r;
    cfg_nxt     = cfg_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    cur_nxt     = cur_r;
    cand_nxt    = cand_r;
    t_nxt       = t_r;
    res_nxt     = res_r;
    qerr_nxt    = qerr_r;
    out_ca_nxt  = out_ca_r;
    out_err_nxt = out_err_r;
    out_valid_nxt = out_valid_r;
    anc_rlvl  = '0;
    anc_rnode = '0;
    anc_we    = 1'b0;
    anc_wlvl  = '0;
    anc_wnode = i_r;
    anc_wdata = '0;
    dep_raddr = '0;
    dep_we    = 1'b0;
    dep_waddr = i_r;
    dep_wdata = '0;
    chg       = changed_r;

    // Drop the result once taken.
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_CLR: begin
        anc_we = 1'b1;
        i_nxt  = i_r + NB'(1);
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_ch.mode)
            MODE_CLEAR: begin
              i_nxt     = '0;
              built_nxt = 1'b0;
            end
            MODE_SET: begin
              if (a_ok && b_par_ok) begin
                anc_we    = 1'b1;
                anc_wnode = a_nb;
                anc_wdata = b_nb;
                built_nxt = 1'b0;
              end
            end
            MODE_BUILD: begin
              i_nxt = NB'(1);
              if (n_nb == '0) built_nxt = 1'b1;
            end
            default: begin
              x_nxt    = a_nb;
              y_nxt    = b_nb;
              res_nxt  = '0;
              qerr_nxt = 1'b1;
              if (built_r && a_ok && b_ok) qerr_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_FIX_RD: anc_rnode = i_r;
      ST_FIX_WR: begin
        // Clear parents beyond the count; zero the node's depth.
        if (anc_q > n_nb) anc_we = 1'b1;
        dep_we = 1'b1;
        if (i_last) begin
          i_nxt       = NB'(1);
          changed_nxt = 1'b0;
        end else begin
          i_nxt = i_r + NB'(1);
        end
      end
      ST_P_RD: begin
        anc_rnode = i_r;
        dep_raddr = i_r;
      end
      ST_P_CHK: begin
        if (dep_q == '0) begin
          if (anc_q == '0) begin
            dep_we    = 1'b1;
            dep_wdata = NB'(1);
            chg       = 1'b1;
          end else begin
            dep_raddr = anc_q;
          end
        end
        if (!(dep_q == '0 && anc_q != '0)) begin
          if (i_last) begin
            i_nxt       = NB'(1);
            changed_nxt = 1'b0;
          end else begin
            i_nxt       = i_r + NB'(1);
            changed_nxt = chg;
          end
        end
      end
      ST_P_WR: begin
        if (dep_q != '0) begin
          dep_we    = 1'b1;
          dep_wdata = dep_q + NB'(1);
          chg       = 1'b1;
        end
        if (i_last) begin
          i_nxt       = NB'(1);
          changed_nxt = 1'b0;
        end else begin
          i_nxt       = i_r + NB'(1);
          changed_nxt = chg;
        end
      end
      ST_R_RD: dep_raddr = i_r;
      ST_R_WR: begin
        // Unresolved nodes sit on or behind a cycle: make them roots.
        if (dep_q == '0) begin
          anc_we    = 1'b1;
          dep_we    = 1'b1;
          dep_wdata = NB'(1);
        end
        i_nxt = i_r + NB'(1);
        if (i_last) begin
          i_nxt = NB'(1);
          k_nxt = LB'(1);
        end
      end
      ST_L_RD1: begin
        anc_rlvl  = k_r - LB'(1);
        anc_rnode = i_r;
      end
      ST_L_RD2: begin
        anc_rlvl  = k_r - LB'(1);
        anc_rnode = anc_q;
      end
      ST_L_WR: begin
        anc_we    = 1'b1;
        anc_wlvl  = k_r;
        anc_wdata = anc_q;
        i_nxt     = i_r + NB'(1);
        if (i_last) begin
          i_nxt = NB'(1);
          if (k_r == K_TOP) built_nxt = 1'b1;
          else              k_nxt = k_r + LB'(1);
        end
      end
      ST_Q_DY: dep_raddr = y_r;
      ST_Q_SET: begin
        t_nxt     = dep_q;
        cur_nxt   = x_r;
        phase_nxt = 1'b0;
        k_nxt     = K_TOP;
      end
      ST_LF_A: begin
        anc_rlvl  = k_r;
        anc_rnode = cur_r;
      end
      ST_LF_B: begin
        cand_nxt  = anc_q;
        dep_raddr = anc_q;
      end
      ST_LF_C: begin
        if (dep_q >= t_r) cur_nxt = cand_r;
        if (k_r != '0) k_nxt = k_r - LB'(1);
      end
      ST_LF_G: dep_raddr = cur_r;
      ST_LF_H: begin
        if (dep_q > t_r) begin
          anc_rnode = cur_r;
        end else if (!phase_r) begin
          x_nxt     = cur_r;
          t_nxt     = dep_q;
          cur_nxt   = y_r;
          phase_nxt = 1'b1;
          k_nxt     = K_TOP;
        end else begin
          y_nxt = cur_r;
          k_nxt = K_TOP;
        end
      end
      ST_LF_I: cur_nxt = anc_q;
      ST_J_A: begin
        anc_rlvl  = k_r;
        anc_rnode = x_r;
      end
      ST_J_B: begin
        cand_nxt  = anc_q;
        anc_rlvl  = k_r;
        anc_rnode = y_r;
      end
      ST_J_C: begin
        if (cand_r != anc_q) begin
          x_nxt = cand_r;
          y_nxt = anc_q;
        end
        if (k_r != '0) k_nxt = k_r - LB'(1);
      end
      ST_F_A: begin
        if (x_r == y_r) begin
          res_nxt  = x_r;
          qerr_nxt = 1'b0;
        end else begin
          anc_rnode = x_r;
        end
      end
      ST_F_B: begin
        x_nxt     = anc_q;
        anc_rnode = y_r;
      end
      ST_F_C: y_nxt = anc_q;
      ST_Q_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ca_nxt    = res_r;
          out_err_nxt   = qerr_r;
        end
      end
      default: ;
    endcase

    // The user makes config writes only while idle; the block does not enforce it. They invalidate the tables.
    if (cfg_we) begin
      cfg_nxt   = cfg_wdata;
      built_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      i_r         <= '0;
      k_r         <= '0;
      changed_r   <= 1'b0;
      built_r     <= 1'b0;
      phase_r     <= 1'b0;
      cfg_r       <= CFG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      changed_r   <= changed_nxt;
      built_r     <= built_nxt;
      phase_r     <= phase_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    cur_r     <= cur_nxt;
    cand_r    <= cand_nxt;
    t_r       <= t_nxt;
    res_r     <= res_nxt;
    qerr_r    <= qerr_nxt;
    out_ca_r  <= out_ca_nxt;
    out_err_r <= out_err_nxt;
  end

  // Ancestor memory: address is {level, node}.
  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[{anc_wlvl, anc_wnode}] <= anc_wdata;
    anc_rd_r   <= anc_mem[{anc_rlvl, anc_rnode}];
    anc_zero_r <= (anc_rnode == '0);
  end

  // Depth memory.
  always_ff @(posedge clk) begin
    if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
    dep_rd_r   <= dep_mem[dep_raddr];
    dep_zero_r <= (dep_raddr == '0);
  end

endmodule

### hdl/lca_chk.sv
module lca_chk import lca_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] out_common_ancestor,
  input logic               out_query_error
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_common_ancestor) && $stable(out_query_error))
    else $error("stalled result beat changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_query_error |-> out_common_ancestor == '0)
    else $error("error result carries a nonzero ancestor");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_QUERY |=> !in_ready)
    else $error("ready right after a query beat");

endmodule

bind lca_binary_lifting_top lca_chk u_lca_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_mode             (in_ch.mode),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_common_ancestor (out_ch.common_ancestor),
  .out_query_error     (out_ch.query_error)
);

### tb/sv/lca_binary_lifting_top_tb.sv
module lca_binary_lifting_top_tb;
  import lca_pkg::*;

  localparam int NODE_BITS = 10;
  localparam int LEVELS    = 10;
  localparam int SLOTS     = 1 << NODE_BITS;
  localparam int LIMIT     = 6000000;
  localparam int NO_CFG    = -1;

  typedef struct {
    logic [FIELD_W-1:0] ancestor;
    logic               err;
  } answer_t;

  typedef struct {
    int                 cfg_before;
    logic [1:0]         mode;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    bit                 typed;
    logic [FIELD_W-1:0] ancestor;
    logic               err;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lca_in_if  in_ch ();
  lca_out_if out_ch ();

  lca_binary_lifting_top #(.NODE_BITS(NODE_BITS), .LEVELS(LEVELS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow tree state
  logic [FIELD_W-1:0] jump [LEVELS][SLOTS];
  logic [FIELD_W-1:0] level_of [SLOTS];
  bit                 tree_built;
  int                 nodes_used;

  answer_t pending_answers[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      beats_sent = 0;
  bit      calm = 0;       // both sides run without gaps
  bit      hold_req = 0;   // ask the receiver for one long hold-off

  function automatic void tree_clear();
    for (int k = 0; k < LEVELS; k++)
      for (int i = 0; i < SLOTS; i++) jump[k][i] = '0;
    for (int i = 0; i < SLOTS; i++) level_of[i] = '0;
    tree_built = 0;
  endfunction

  function automatic void tree_build();
    int  n;
    bit  changed;
    int  p;
    int  d;
    n = nodes_used;
    changed = 1;
    for (int i = 0; i < SLOTS; i++) level_of[i] = '0;
    for (int i = 1; i <= n; i++)
      if (jump[0][i] > n) jump[0][i] = '0;
    for (int pass = 0; pass <= n && changed; pass++) begin
      changed = 0;
      for (int i = 1; i <= n; i++) begin
        if (level_of[i] != 0) continue;
        p = int'(jump[0][i]);
        if (p == 0) d = 1;
        else if (level_of[p] != 0) d = int'(level_of[p]) + 1;
        else d = 0;
        if (d != 0) begin
          level_of[i] = FIELD_W'(d);
          changed = 1;
        end
      end
    end
    // whatever is left sits in or behind a loop: make it a root
    for (int i = 1; i <= n; i++)
      if (level_of[i] == 0) begin
        jump[0][i] = '0;
        level_of[i] = FIELD_W'(1);
      end
    for (int k = 1; k < LEVELS; k++) begin
      jump[k][0] = '0;
      for (int i = 1; i <= n; i++) jump[k][i] = jump[k-1][jump[k-1][i]];
    end
    tree_built = 1;
  endfunction

  function automatic int lift(int x, int target);
    int guard;
    guard = 0;
    for (int k = LEVELS - 1; k >= 0; k--)
      if (level_of[jump[k][x]] >= target) x = int'(jump[k][x]);
    while (guard < SLOTS && level_of[x] > target) begin
      x = int'(jump[0][x]);
      guard++;
    end
    return x;
  endfunction

  function automatic answer_t common_ancestor_of(int x, int y);
    answer_t r;
    int guard;
    guard = 0;
    r.ancestor = '0;
    r.err = 1'b1;
    if (!tree_built || x < 1 || x > nodes_used || y < 1 || y > nodes_used) return r;
    x = lift(x, int'(level_of[y]));
    y = lift(y, int'(level_of[x]));
    for (int k = LEVELS - 1; k >= 0; k--)
      if (jump[k][x] != jump[k][y]) begin
        x = int'(jump[k][x]);
        y = int'(jump[k][y]);
      end
    while (guard < SLOTS && x != y) begin
      x = int'(jump[0][x]);
      y = int'(jump[0][y]);
      guard++;
    end
    r.err = 1'b0;
    r.ancestor = (x == y) ? x[FIELD_W-1:0] : '0;
    return r;
  endfunction

  // Apply one accepted beat to the shadow tree; queries return an answer.
  function automatic bit tree_step(logic [1:0] mode, int a, int b, output answer_t r);
    r.ancestor = '0;
    r.err = 1'b0;
    case (mode)
      MODE_CLEAR: tree_clear();
      MODE_SET: begin
        if (a >= 1 && a <= nodes_used && b <= nodes_used) begin
          jump[0][a] = b[FIELD_W-1:0];
          tree_built = 0;
        end
      end
      MODE_BUILD: tree_build();
      default: begin
        r = common_ancestor_of(a, b);
        return 1;
      end
    endcase
    return 0;
  endfunction

  // Offer one beat after a random gap; return once it is taken.
  task automatic send_beat(logic [1:0] mode, int a, int b, bit typed = 0,
                           answer_t typed_ans = '{default: '0});
    int      gap;
    answer_t r;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.node_a <= a[FIELD_W-1:0];
    in_ch.node_b <= b[FIELD_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    if (tree_step(mode, a, b, r)) begin
      if (typed) r = typed_ans;
      pending_answers = {pending_answers, r};
    end
    beats_sent++;
  endtask

  // Drain: every answer in, and the sequencer back to taking beats.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0 || !in_ch.ready) @(posedge clk);
  endtask

  task automatic write_count(int value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    nodes_used = value;
    tree_built = 0;
  endtask

  // Receiver: random stalls, one long hold-off on request, check every beat.
  initial begin
    int      stall;
    answer_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected beat ancestor=%0d err=%0b", $time,
                 out_ch.common_ancestor, out_ch.query_error);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.common_ancestor !== want.ancestor) begin
          $display("%0t: common_ancestor expected %0d actual %0d", $time,
                   want.ancestor, out_ch.common_ancestor);
          fail_count++;
        end
        if (out_ch.query_error !== want.err) begin
          $display("%0t: query_error expected %0b actual %0b", $time,
                   want.err, out_ch.query_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  row_t    script[$];
  answer_t typed_ans;

  initial begin
    int      n;
    int      pick;
    int      child;
    int      parent;
    int      big_left;
    int      phase;
    int      touched[$];
    row_t    row;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.mode   <= MODE_CLEAR;
    in_ch.node_a <= '0;
    in_ch.node_b <= '0;
    tree_clear();
    nodes_used = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: typed answers where they are obvious, predictor elsewhere.
    script = '{
      '{NO_CFG, MODE_QUERY, 1,    1,    1, 0,    1},  // query before build
      '{NO_CFG, MODE_BUILD, 0,    0,    0, 0,    0},
      '{NO_CFG, MODE_QUERY, 1,    1,    1, 1,    0},  // lone root
      '{NO_CFG, MODE_QUERY, 0,    0,    1, 0,    1},  // node zero
      '{NO_CFG, MODE_QUERY, 1023, 1,    1, 0,    1},  // beyond count
      '{NO_CFG, MODE_SET,   1,    1,    0, 0,    0},  // self loop
      '{NO_CFG, MODE_SET,   0,    0,    0, 0,    0},  // ignored child
      '{NO_CFG, MODE_SET,   1,    1023, 0, 0,    0},  // ignored parent
      '{NO_CFG, MODE_BUILD, 0,    0,    0, 0,    0},
      '{NO_CFG, MODE_QUERY, 1,    1,    1, 1,    0},
      '{1023,   MODE_QUERY, 1,    1,    1, 0,    1},  // config drops build
      '{NO_CFG, MODE_SET,   1023, 5,    0, 0,    0},
      '{NO_CFG, MODE_SET,   5,    1023, 0, 0,    0},  // two-node loop
      '{NO_CFG, MODE_SET,   2,    1,    0, 0,    0},
      '{NO_CFG, MODE_SET,   3,    1,    0, 0,    0},
      '{NO_CFG, MODE_SET,   682,  3,    0, 0,    0},
      '{NO_CFG, MODE_BUILD, 0,    0,    0, 0,    0},
      '{NO_CFG, MODE_QUERY, 2,    682,  0, 0,    0},
      '{NO_CFG, MODE_QUERY, 1023, 5,    0, 0,    0},
      '{NO_CFG, MODE_QUERY, 1023, 1023, 1, 1023, 0},
      '{NO_CFG, MODE_QUERY, 341,  682,  0, 0,    0},  // separate trees
      '{4,      MODE_BUILD, 0,    0,    0, 0,    0},  // count shrunk to four
      '{NO_CFG, MODE_QUERY, 5,    2,    1, 0,    1},
      '{NO_CFG, MODE_CLEAR, 0,    0,    0, 0,    0},
      '{NO_CFG, MODE_QUERY, 2,    3,    1, 0,    1}   // cleared
    };
    foreach (script[i]) begin
      row = script[i];
      if (row.cfg_before != NO_CFG) write_count(row.cfg_before);
      typed_ans.ancestor = row.ancestor;
      typed_ans.err      = row.err;
      send_beat(row.mode, int'(row.a), int'(row.b), row.typed, typed_ans);
    end

    // Random phases: mostly well-formed trees, then build, then queries.
    big_left = 2;
    phase = 0;
    while (beats_sent < 900) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) n = 1;
      else if (pick == 1 && big_left > 0) begin
        n = 1023;
        big_left--;
      end else if (pick == 2) n = $urandom_range(100, 300);
      else n = $urandom_range(2, 40);
      write_count(n);
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 3) hold_req = 1;
      touched.delete();
      if (n >= 100 || $urandom_range(0, 3) == 0) send_beat(MODE_CLEAR, 0, 0);
      repeat ((n < 40 ? n : 40)) begin
        child = $urandom_range(1, n);
        pick = $urandom_range(0, 19);
        if (pick < 16) parent = $urandom_range(0, child - 1);
        else if (pick < 18) parent = $urandom_range(0, n);
        else begin
          child = $urandom_range(0, 1023);
          parent = $urandom_range(0, 1023);
        end
        touched = {touched, child};
        send_beat(MODE_SET, child, parent);
      end
      if ($urandom_range(0, 9) != 0) send_beat(MODE_BUILD, 0, 0);
      repeat ($urandom_range(10, 20)) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_beat(2'($urandom_range(0, 2)), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023));
        else if (pick < 3 || touched.size() == 0)
          send_beat(MODE_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          send_beat(MODE_QUERY, touched[$urandom_range(0, touched.size() - 1)],
                    touched[$urandom_range(0, touched.size() - 1)]);
      end
      phase++;
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
